>>> sv/tlbmmu_pkg.sv
// Shared types and constants for the TLB / demand-paging MMU.
package tlbmmu_pkg;

  localparam int unsigned PAGE_WMAX  = 12;
  localparam int unsigned FRAME_WMAX = 12;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned STAMP_W    = 32;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic [PAGE_WMAX-1:0]  page;
    logic [ADDR_W-1:0]     offset;
    logic [STAMP_W-1:0]    now;
    logic                  hit;
    logic [FRAME_WMAX-1:0] frame;
  } item_t;

  typedef struct packed {
    logic                  inval;
    logic [PAGE_WMAX-1:0]  inval_page;
    logic                  refill;
    logic [PAGE_WMAX-1:0]  page;
    logic [FRAME_WMAX-1:0] frame;
    logic [STAMP_W-1:0]    now;
  } tlb_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_addr;
    logic [7:0]        frame_number;
    logic              tlb_hit;
    logic              fault;
    logic              evicted_valid;
    logic [7:0]        evicted_page;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_LOOK,
    F_SCAN
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_TREAD,
    B_OREAD,
    B_CHECK,
    B_SCAN,
    B_VREAD,
    B_EVICT,
    B_MAP,
    B_REFILL,
    B_WAIT,
    B_OUT
  } back_state_e;

endpackage

>>> sv/tlbmmu_fifo.sv
// Two-entry item queue between front and back.
module tlbmmu_fifo import tlbmmu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t data_o
);

  item_t      mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

>>> sv/tlbmmu_front.sv
// Front end: takes addresses, reduces page number, searches the TLB, keeps TLB state.
module tlbmmu_front import tlbmmu_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 8,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [ADDR_W-1:0] va_i,
  output logic              push_o,
  output item_t             item_o,
  input  tlb_cmd_t          cmd_i,
  output logic              refill_done_o
);

  localparam int unsigned PB = $clog2(PAGE_COUNT);
  localparam int unsigned FB = $clog2(FRAME_COUNT);
  localparam int unsigned TB = $clog2(TLB_ENTRIES);
  localparam logic [39:0] RECIP = 40'((64'd1 << 24) / PAGE_COUNT);
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((32'd1 << OFFSET_BITS) - 32'd1);

  front_state_e state_q, state_d;

  logic [ADDR_W-1:0]  va_q;
  logic [STAMP_W-1:0] clock_q;
  logic [STAMP_W-1:0] now_q;
  logic [STAMP_W-1:0] clock_nx;
  logic [ADDR_W-1:0]  vpn;
  logic [ADDR_W-1:0]  vpn_q;
  logic [ADDR_W-1:0]  quot_q;
  logic [31:0]        rem;
  logic [PB-1:0]      page;

  logic                tlb_valid_q [TLB_ENTRIES];
  logic [PB-1:0]       tlb_page_q  [TLB_ENTRIES];
  logic [FB-1:0]       tlb_frame_q [TLB_ENTRIES];
  logic [STAMP_W-1:0]  tlb_stamp_q [TLB_ENTRIES];

  logic          hit;
  logic [TB-1:0] hidx;

  logic [TB-1:0]      sidx_q;
  logic [TB-1:0]      pick_q;
  logic [TB-1:0]      pick_n;
  logic [STAMP_W-1:0] best_q;
  logic [STAMP_W-1:0] best_n;
  logic               last;
  logic [PB-1:0]      rf_page_q;
  logic [FB-1:0]      rf_frame_q;
  logic [STAMP_W-1:0] rf_now_q;
  logic               done_q;

  assign clock_nx = (clock_q == STAMP_MAX) ? clock_q : clock_q + 32'd1;
  assign vpn      = ADDR_W'(va_q >> OFFSET_BITS);

  // page = vpn mod PAGE_COUNT via reciprocal, one correction step
  always_comb begin
    rem = 32'(vpn_q) - 32'(quot_q) * 32'(PAGE_COUNT);
    if (rem >= 32'(PAGE_COUNT)) rem = rem - 32'(PAGE_COUNT);
    page = PB'(rem);
  end

  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page)) begin
        hit  = 1'b1;
        hidx = TB'(i);
      end
    end
  end

  always_comb begin
    if (tlb_stamp_q[sidx_q] < best_q) begin
      best_n = tlb_stamp_q[sidx_q];
      pick_n = sidx_q;
    end else begin
      best_n = best_q;
      pick_n = pick_q;
    end
    last = (sidx_q == TB'(TLB_ENTRIES - 1));
  end

  always_comb begin
    state_d       = state_q;
    push_o        = 1'b0;
    item_o        = '0;
    item_o.page   = PAGE_WMAX'(page);
    item_o.offset = va_q & OFF_MASK;
    item_o.now    = now_q;
    item_o.hit    = hit;
    item_o.frame  = FRAME_WMAX'(tlb_frame_q[hidx]);
    case (state_q)
      F_IDLE: begin
        if (accept_i) state_d = F_MOD;
        else if (cmd_i.refill) state_d = F_SCAN;
      end
      F_MOD: state_d = F_LOOK;
      F_LOOK: begin
        push_o  = 1'b1;
        state_d = F_IDLE;
      end
      F_SCAN: begin
        if (last) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid_q[i] <= 1'b0;
        tlb_page_q[i]  <= '0;
        tlb_frame_q[i] <= '0;
        tlb_stamp_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (state_q == F_IDLE && accept_i) clock_q <= clock_nx;
      if (state_q == F_LOOK && hit) tlb_stamp_q[hidx] <= now_q;
      if (cmd_i.inval) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tlb_valid_q[i] && (tlb_page_q[i] == PB'(cmd_i.inval_page))) begin
            tlb_valid_q[i] <= 1'b0;
            tlb_stamp_q[i] <= '0;
          end
        end
      end
      if (state_q == F_SCAN && last) begin
        tlb_valid_q[pick_n] <= 1'b1;
        tlb_page_q[pick_n]  <= rf_page_q;
        tlb_frame_q[pick_n] <= rf_frame_q;
        tlb_stamp_q[pick_n] <= rf_now_q;
        done_q              <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept_i) begin
          va_q  <= va_i;
          now_q <= clock_nx;
        end else if (cmd_i.refill) begin
          rf_page_q  <= PB'(cmd_i.page);
          rf_frame_q <= FB'(cmd_i.frame);
          rf_now_q   <= cmd_i.now;
          best_q     <= cmd_i.now;
          pick_q     <= '0;
          sidx_q     <= '0;
        end
      end
      F_MOD: begin
        vpn_q  <= vpn;
      end
      F_SCAN: begin
        best_q <= best_n;
        pick_q <= pick_n;
        sidx_q <= sidx_q + TB'(1);
      end
      default: ;
    endcase
    if (state_q == F_MOD) quot_q <= ADDR_W'(((40'(vpn)) * RECIP) >> 24);
  end

  assign refill_done_o = done_q;

endmodule

>>> sv/tlbmmu_back.sv
// Back end: page table, frame ownership, frame LRU scan and result assembly.
module tlbmmu_back import tlbmmu_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 8,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  item_t    q_data_i,
  output logic     q_pop_o,
  output tlb_cmd_t cmd_o,
  input  logic     refill_done_i,
  output logic     done_o,
  output result_t  result_o
);

  localparam int unsigned PB = $clog2(PAGE_COUNT);
  localparam int unsigned FB = $clog2(FRAME_COUNT);
  localparam logic [FB:0] FCOUNT = (FB + 1)'(FRAME_COUNT);
  localparam logic [FB-1:0] FLAST = FB'(FRAME_COUNT - 1);

  back_state_e state_q, state_d;

  logic [FB-1:0]      tf_mem  [PAGE_COUNT];
  logic [PB-1:0]      own_mem [FRAME_COUNT];
  logic [STAMP_W-1:0] stp_mem [FRAME_COUNT];

  logic [FB-1:0]      tf_rd_q;
  logic [PB-1:0]      own_rd_q;
  logic [STAMP_W-1:0] stp_rd_q;
  logic [FB-1:0]      own_raddr;

  item_t              item_q;
  logic [PB-1:0]      page;
  logic [FB-1:0]      tf_q;
  logic [FB-1:0]      frame_q;
  logic [FB:0]        fill_q;
  logic               fault_q;
  logic               evv_q;
  logic [PB-1:0]      evp_q;
  logic [FB:0]        sc_q;
  logic               rdv_q;
  logic [FB-1:0]      rdi_q;
  logic [STAMP_W-1:0] best_q;
  logic [FB-1:0]      pick_q;
  logic               mapped;
  logic               scan_end;

  assign page      = item_q.page[PB-1:0];
  assign own_raddr = (state_q == B_OREAD) ? tf_rd_q : pick_q;
  assign scan_end  = rdv_q && (rdi_q == FLAST);

  // page is resident when its table entry names a used frame that it owns
  always_comb begin
    mapped = 1'b0;
    if (({1'b0, tf_q} < fill_q) && (own_rd_q == page)) mapped = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    cmd_o   = '0;
    cmd_o.inval_page = PAGE_WMAX'(own_rd_q);
    cmd_o.page       = PAGE_WMAX'(page);
    cmd_o.frame      = FRAME_WMAX'(frame_q);
    cmd_o.now        = item_q.now;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.hit) state_d = B_OUT;
          else state_d = B_TREAD;
        end
      end
      B_TREAD: state_d = B_OREAD;
      B_OREAD: state_d = B_CHECK;
      B_CHECK: begin
        if (mapped) state_d = B_REFILL;
        else if (fill_q < FCOUNT) state_d = B_MAP;
        else state_d = B_SCAN;
      end
      B_SCAN: begin
        if (scan_end) state_d = B_VREAD;
      end
      B_VREAD: state_d = B_EVICT;
      B_EVICT: begin
        cmd_o.inval = 1'b1;
        state_d     = B_MAP;
      end
      B_MAP: state_d = B_REFILL;
      B_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = B_WAIT;
      end
      B_WAIT: begin
        if (refill_done_i) state_d = B_OUT;
      end
      B_OUT: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else state_q <= state_d;
  end

  // frames are handed out in index order until all are used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fill_q <= '0;
    else if (state_q == B_CHECK && !mapped && fill_q < FCOUNT) fill_q <= fill_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    tf_rd_q  <= tf_mem[page];
    own_rd_q <= own_mem[own_raddr];
    stp_rd_q <= stp_mem[sc_q[FB-1:0]];
    if (state_q == B_MAP) begin
      tf_mem[page]     <= frame_q;
      own_mem[frame_q] <= page;
    end
    if (state_q == B_OUT) stp_mem[frame_q] <= item_q.now;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        item_q  <= q_data_i;
        frame_q <= q_data_i.frame[FB-1:0];
        fault_q <= 1'b0;
        evv_q   <= 1'b0;
        evp_q   <= '0;
      end
      B_OREAD: tf_q <= tf_rd_q;
      B_CHECK: begin
        if (mapped) begin
          frame_q <= tf_q;
        end else begin
          fault_q <= 1'b1;
          frame_q <= fill_q[FB-1:0];
          sc_q    <= '0;
          rdv_q   <= 1'b0;
          best_q  <= item_q.now;
          pick_q  <= '0;
        end
      end
      B_SCAN: begin
        if (sc_q < FCOUNT) sc_q <= sc_q + 1'b1;
        rdv_q <= (sc_q < FCOUNT);
        rdi_q <= sc_q[FB-1:0];
        if (rdv_q && (stp_rd_q < best_q)) begin
          best_q <= stp_rd_q;
          pick_q <= rdi_q;
        end
      end
      B_VREAD: frame_q <= pick_q;
      B_EVICT: begin
        evv_q <= 1'b1;
        evp_q <= own_rd_q;
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == B_OUT);

  always_comb begin
    result_o.phys_addr =
      ADDR_W'((32'(frame_q) << OFFSET_BITS) | 32'(item_q.offset));
    result_o.frame_number  = 8'(32'(frame_q));
    result_o.tlb_hit       = item_q.hit;
    result_o.fault         = fault_q;
    result_o.evicted_valid = evv_q;
    result_o.evicted_page  = 8'(32'(evp_q));
  end

endmodule

>>> sv/tlb_lru_demand_paging_mmu.sv
// Top level of the TLB / LRU demand-paging MMU.
//
// Usage notes:
// - Command port: an item (virtual_address_i) is taken at a rising edge with
//   start_i high and busy_o low. busy_o stays high until that item's result
//   has been shown, so one item is in work at a time.
// - Result: done_o is high for exactly one cycle with phys_addr_o,
//   frame_number_o, tlb_hit_o, fault_o, evicted_valid_o and
//   evicted_page_o. The receiver cannot stall; it must take it then.
// - The next item can be taken in the cycle after the result. The TLB
//   refill search walks TLB_ENTRIES stamps one per cycle; the frame victim
//   search reads one stamp per cycle.
// - Structure: the front end reduces the page number and searches the TLB,
//   a two-entry queue holds the classified item, the back end does page
//   table, frame allocation, eviction and commands TLB invalidate/refill.
// - Reset (rst_ni low, asynchronous): TLB empty, page table empty, no frame
//   in use, access clock zero. No clearing pass; items may start right away.
module tlb_lru_demand_paging_mmu import tlbmmu_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 8,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] virtual_address_i,
  output logic        done_o,
  output logic [15:0] phys_addr_o,
  output logic [7:0]  frame_number_o,
  output logic        tlb_hit_o,
  output logic        fault_o,
  output logic        evicted_valid_o,
  output logic [7:0]  evicted_page_o
);

  logic     busy_q;
  logic     accept;
  logic     push;
  item_t    push_item;
  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  tlb_cmd_t cmd;
  logic     refill_done;
  logic     done;
  result_t  res;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  // busy from accept until the result cycle has passed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (accept) busy_q <= 1'b1;
    else if (done) busy_q <= 1'b0;
  end

  tlbmmu_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .va_i          (virtual_address_i),
    .push_o        (push),
    .item_o        (push_item),
    .cmd_i         (cmd),
    .refill_done_o (refill_done)
  );

  tlbmmu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  tlbmmu_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_item),
    .q_pop_o       (q_pop),
    .cmd_o         (cmd),
    .refill_done_i (refill_done),
    .done_o        (done),
    .result_o      (res)
  );

  assign done_o          = done;
  assign phys_addr_o     = res.phys_addr;
  assign frame_number_o  = res.frame_number;
  assign tlb_hit_o       = res.tlb_hit;
  assign fault_o         = res.fault;
  assign evicted_valid_o = res.evicted_valid;
  assign evicted_page_o  = res.evicted_page;

  // a result only belongs to an item in work
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q) else $error("result without item in work");

  // hit and fault exclude each other
  a_hit_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !(res.tlb_hit && res.fault)) else $error("hit and fault together");

  // an eviction only happens on a fault
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && res.evicted_valid) |-> res.fault) else $error("eviction without fault");

  // an item is only pushed into the queue while an item is in work
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> busy_q) else $error("item pushed while idle");

endmodule
